// ----- design/acrms_pkg.sv -----
package acrms_pkg;

  localparam int ACC_W     = 50;
  localparam int OUT_W     = 40;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam int SC_W  = 13;
  localparam int CT_W  = 14;
  localparam int RS_W  = 14;
  localparam int VPC_W = 24;
  localparam int P1_W  = CT_W + VPC_W;

  localparam int SC_RESET  = 1000;
  localparam int CT_RESET  = 2000;
  localparam int RS_RESET  = 100;
  localparam int VPC_RESET = 81920;

  localparam int OFFSET_RESET_Q8 = 510 * 256;
  localparam int CUR_OFS_Q10     = 82;
  localparam int SCALE_SHIFT     = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_COUNT    = 2'd0,
    CFG_CT_RATIO        = 2'd1,
    CFG_SENSE_RES       = 2'd2,
    CFG_VOLTS_PER_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_OFFSET,
    ST_FACTOR,
    ST_MEAN,
    ST_ROOT,
    ST_SCALE,
    ST_CURRENT,
    ST_EMIT
  } state_e;

endpackage

// ----- design/acrms_serial_mul.sv -----
module acrms_serial_mul #(
  parameter int AW = 38,
  parameter int BW = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [AW-1:0]  a_i,
  input  logic [BW-1:0]  b_i,
  output logic           done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_q;
  logic [AW-1:0] hi_q, hi_d;
  logic [BW-1:0] lo_q, lo_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [AW:0]   sum;
  logic [AW+BW-1:0] shifted;

  always_comb begin
    sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
    shifted = {sum, lo_q[BW-1:1]};
    hi_d    = shifted[AW+BW-1:BW];
    lo_d    = shifted[BW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

// ----- design/acrms_serial_div.sv -----
module acrms_serial_div #(
  parameter int NW = 50,
  parameter int DW = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[NW-1]};
    ge    = (trial >= {1'b0, den_q});
    rem_d = ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- design/acrms_isqrt.sv -----
module acrms_isqrt #(
  parameter int VW = 50
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [VW-1:0]        val_i,
  output logic                 done_o,
  output logic [(VW+1)/2-1:0]  root_o
);

  localparam int RW = (VW + 1) / 2;
  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] val_q;
  logic [RW:0]     rem_q, rem_d;
  logic [RW-1:0]   root_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [RW+2:0]   trial_rem;
  logic [RW+2:0]   trial;
  logic            ge;

  always_comb begin
    trial_rem = {rem_q, val_q[2*RW-1:2*RW-2]};
    trial     = {1'b0, root_q, 2'b01};
    ge        = (trial_rem >= trial);
    rem_d     = ge ? (RW+1)'(trial_rem - trial) : (RW+1)'(trial_rem);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= (2*RW)'(val_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[2*RW-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- design/ac_current_rms_meter.sv -----
// Channel  Dir  Payload (low bit up)        Handshake
// s_axis   in   tdata: sample               tvalid / tready
// m_axis   out  tdata: rms_current          tvalid / tready
// cfg      in   cfg_idx_i, cfg_data_i       cfg_we_i, no wait
//
// For each word the deviation is squared by a 1-bit-per-cycle shift-add
// multiplier running max(ADC_BITS+8, 25) steps.
// A completed offset block adds a restoring divide.
// A finished measurement adds two divides, a square root and two multiplies
// before the word reaches the output register.
// Reset returns the registers to their defaults and the offset to 510 counts.
// One result waits in the output register while the next word is processed.
module ac_current_rms_meter #(
  parameter int ADC_BITS     = 10,
  parameter int OFFSET_BLOCK = 1000,
  parameter int MAX_SAMPLES  = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [acrms_pkg::OUT_W-1:0]       m_axis_tdata,  // rms_current
  input  logic                              cfg_we_i,
  input  logic [acrms_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [acrms_pkg::CFG_W-1:0]       cfg_data_i
);

  import acrms_pkg::*;

  localparam int OFS_W  = ((ADC_BITS > 9) ? ADC_BITS : 9) + 8;
  localparam int BLK_CW = $clog2(OFFSET_BLOCK + 1);
  localparam int BLK_SW = ADC_BITS + BLK_CW;
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int DIV_NW = (ACC_W > BLK_SW + 8) ? ACC_W : BLK_SW + 8;
  localparam int DV1_W  = (RS_W > CNT_W) ? RS_W : CNT_W;
  localparam int DIV_DW = (DV1_W > BLK_CW) ? DV1_W : BLK_CW;
  localparam int RT_W   = (ACC_W + 1) / 2;
  localparam int MUL_AW = (OFS_W > P1_W) ? OFS_W : P1_W;
  localparam int MUL_BW = (OFS_W > RT_W) ? OFS_W : RT_W;
  localparam int PW     = MUL_AW + MUL_BW;
  localparam int AMP_W  = PW - SCALE_SHIFT + 1;

  state_e state_q, state_d;

  logic [SC_W-1:0]  sc_q;
  logic [CT_W-1:0]  ct_q;
  logic [RS_W-1:0]  rs_q;
  logic [VPC_W-1:0] vpc_q;

  logic [CNT_W-1:0]  smp_cnt_q, smp_cnt_d;
  logic [BLK_CW-1:0] blk_cnt_q, blk_cnt_d;
  logic [BLK_SW-1:0] blk_sum_q, blk_sum_d;
  logic [OFS_W-1:0]  ofs_q, ofs_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              end_q, end_d;
  logic [CT_W-1:0]   factor_q, factor_d;
  logic [P1_W-1:0]   p1_q, p1_d;
  logic [OUT_W-1:0]  out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              mul_start, mul_done;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PW-1:0]     mul_prod;
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] div_quo;
  logic              sq_start, sq_done;
  logic [RT_W-1:0]   sq_root;

  logic [ADC_BITS-1:0] raw;
  logic [OFS_W-1:0]    scaled;
  logic [OFS_W-1:0]    mag;
  logic [CNT_W-1:0]    count_w;
  logic [RS_W-1:0]     rs_w;
  logic [ACC_W:0]      acc_sum;
  logic [AMP_W-1:0]    amps;
  logic [OUT_W-1:0]    out_sat;
  logic                in_fire;

  acrms_serial_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  acrms_serial_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  acrms_isqrt #(.VW(ACC_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .val_i   (div_quo[ACC_W-1:0]),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    raw     = s_axis_tdata[ADC_BITS-1:0];
    scaled  = OFS_W'({raw, 8'h00});
    mag     = (scaled >= ofs_q) ? scaled - ofs_q : ofs_q - scaled;
    if (sc_q == '0) begin
      count_w = CNT_W'(1);
    end else if (32'(sc_q) > 32'(MAX_SAMPLES)) begin
      count_w = CNT_W'(MAX_SAMPLES);
    end else begin
      count_w = CNT_W'(sc_q);
    end
    rs_w    = (rs_q == '0) ? RS_W'(1) : rs_q;
    acc_sum = {1'b0, acc_q} + (ACC_W+1)'(mul_prod[2*OFS_W-1:0]);
    amps    = $signed({1'b0, mul_prod[PW-1:SCALE_SHIFT]}) - $signed(AMP_W'(CUR_OFS_Q10));
    if (!amps[AMP_W-1] && (|amps[AMP_W-2:OUT_W-1])) begin
      out_sat = {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      out_sat = amps[OUT_W-1:0];
    end
  end

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    state_d     = state_q;
    smp_cnt_d   = smp_cnt_q;
    blk_cnt_d   = blk_cnt_q;
    blk_sum_d   = blk_sum_q;
    ofs_d       = ofs_q;
    acc_d       = acc_q;
    end_d       = end_q;
    factor_d    = factor_q;
    p1_d        = p1_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_start   = 1'b0;
    mul_a       = MUL_AW'(mag);
    mul_b       = MUL_BW'(mag);
    div_start   = 1'b0;
    div_num     = DIV_NW'({blk_sum_q, 8'h00});
    div_den     = DIV_DW'(OFFSET_BLOCK);
    sq_start    = 1'b0;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          mul_start = 1'b1;
          blk_sum_d = blk_sum_q + BLK_SW'(raw);
          blk_cnt_d = blk_cnt_q + 1'b1;
          smp_cnt_d = smp_cnt_q + 1'b1;
          end_d     = (smp_cnt_d >= count_w);
          state_d   = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (mul_done) begin
          acc_d = acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
          if (end_q) begin
            div_start = 1'b1;
            div_num   = DIV_NW'(ct_q);
            div_den   = DIV_DW'(rs_w);
            state_d   = ST_FACTOR;
          end else if (blk_cnt_q >= BLK_CW'(OFFSET_BLOCK)) begin
            div_start = 1'b1;
            state_d   = ST_OFFSET;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OFFSET: begin
        if (div_done) begin
          ofs_d     = div_quo[OFS_W-1:0];
          blk_sum_d = '0;
          blk_cnt_d = '0;
          state_d   = ST_IDLE;
        end
      end
      ST_FACTOR: begin
        if (div_done) begin
          factor_d  = div_quo[CT_W-1:0];
          div_start = 1'b1;
          div_num   = DIV_NW'(acc_q);
          div_den   = DIV_DW'(count_w);
          state_d   = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_done) begin
          mul_start = 1'b1;
          mul_a     = MUL_AW'(vpc_q);
          mul_b     = MUL_BW'(factor_q);
          state_d   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (mul_done) begin
          p1_d      = mul_prod[P1_W-1:0];
          mul_start = 1'b1;
          mul_a     = MUL_AW'(p1_d);
          mul_b     = MUL_BW'(sq_root);
          state_d   = ST_CURRENT;
        end
      end
      ST_CURRENT: begin
        if (mul_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = out_sat;
          out_valid_d = 1'b1;
          smp_cnt_d   = '0;
          blk_cnt_d   = '0;
          blk_sum_d   = '0;
          ofs_d       = OFS_W'(OFFSET_RESET_Q8);
          acc_d       = '0;
          end_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      smp_cnt_q   <= '0;
      blk_cnt_q   <= '0;
      blk_sum_q   <= '0;
      ofs_q       <= OFS_W'(OFFSET_RESET_Q8);
      acc_q       <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      smp_cnt_q   <= smp_cnt_d;
      blk_cnt_q   <= blk_cnt_d;
      blk_sum_q   <= blk_sum_d;
      ofs_q       <= ofs_d;
      acc_q       <= acc_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    factor_q <= factor_d;
    p1_q     <= p1_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q  <= SC_W'(SC_RESET);
      ct_q  <= CT_W'(CT_RESET);
      rs_q  <= RS_W'(RS_RESET);
      vpc_q <= VPC_W'(VPC_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_COUNT:    sc_q  <= cfg_data_i[SC_W-1:0];
        CFG_CT_RATIO:        ct_q  <= cfg_data_i[CT_W-1:0];
        CFG_SENSE_RES:       rs_q  <= cfg_data_i[RS_W-1:0];
        CFG_VOLTS_PER_COUNT: vpc_q <= cfg_data_i[VPC_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import acrms_pkg::*;

  localparam int ADC_BITS     = 10;
  localparam int OFFSET_BLOCK = 1000;
  localparam int MAX_SAMPLES  = 4096;
  localparam int IN_W         = ((ADC_BITS + 7) / 8) * 8;
  localparam int ADC_MAX      = (1 << ADC_BITS) - 1;
  localparam int IDLE_WAIT    = 400;
  localparam int HOLD_LEN     = 1500;
  localparam int RANDOM_ITEMS = 330;

  localparam longint unsigned ACC_MAX = (64'd1 << ACC_W) - 64'd1;
  localparam longint          OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;

  typedef enum logic [1:0] {OP_SAMPLE, OP_CONFIG, OP_DRAIN, OP_HOLD} stim_op_e;

  typedef struct {
    stim_op_e         op;
    logic [IN_W-1:0]  word;
    int unsigned      gap;
    cfg_idx_e         idx;
    logic [CFG_W-1:0] value;
  } stim_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we_i      = 1'b0;
  cfg_idx_e         cfg_idx_i     = CFG_SAMPLE_COUNT;
  logic [CFG_W-1:0] cfg_data_i    = '0;

  stim_t            stim_q[$];
  logic [OUT_W-1:0] rms_due[$];
  int unsigned      mismatches = 0;

  bit               in_fire    = 1'b0;
  int unsigned      quiet      = 0;
  int unsigned      gap_seen   = 0;
  logic             hold_req   = 1'b0;
  int unsigned      hold_left  = 0;
  int unsigned      stall_left = 0;
  int unsigned      mode_left  = 0;
  bit               calm       = 1'b0;

  logic [SC_W-1:0]  sc_reg  = SC_W'(SC_RESET);
  logic [CT_W-1:0]  ct_reg  = CT_W'(CT_RESET);
  logic [RS_W-1:0]  rs_reg  = RS_W'(RS_RESET);
  logic [VPC_W-1:0] vpc_reg = VPC_W'(VPC_RESET);

  longint unsigned  sample_cnt = 0;
  longint unsigned  offset_q8  = OFFSET_RESET_Q8;
  longint unsigned  block_sum  = 0;
  longint unsigned  block_cnt  = 0;
  longint unsigned  acc        = 0;

  ac_current_rms_meter #(
    .ADC_BITS    (ADC_BITS),
    .OFFSET_BLOCK(OFFSET_BLOCK),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 120);
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] make_word(input int center, input int spread);
    int              s;
    logic [IN_W-1:0] w;
    s = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (s < 0) begin
      s = 0;
    end else if (s > ADC_MAX) begin
      s = ADC_MAX;
    end
    w = IN_W'($urandom);
    w[ADC_BITS-1:0] = s[ADC_BITS-1:0];
    return w;
  endfunction

  task automatic cfg_shadow_write(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    case (idx)
      CFG_SAMPLE_COUNT: sc_reg  = data[SC_W-1:0];
      CFG_CT_RATIO:     ct_reg  = data[CT_W-1:0];
      CFG_SENSE_RES:    rs_reg  = data[RS_W-1:0];
      default:          vpc_reg = data[VPC_W-1:0];
    endcase
  endtask

  task automatic rms_accumulate(input logic [IN_W-1:0] word, output bit done,
                                output logic [OUT_W-1:0] amps);
    longint unsigned raw, scaled, mag, sq, cnt, rs, factor, mean, root, product;
    longint          cur;
    raw    = 64'(word[ADC_BITS-1:0]);
    scaled = raw << 8;
    mag    = (scaled >= offset_q8) ? scaled - offset_q8 : offset_q8 - scaled;
    sq     = mag * mag;
    acc    = (sq > ACC_MAX - acc) ? ACC_MAX : acc + sq;
    block_sum += raw;
    block_cnt++;
    if (block_cnt >= OFFSET_BLOCK) begin
      offset_q8 = (block_sum << 8) / OFFSET_BLOCK;
      block_sum = 0;
      block_cnt = 0;
    end
    sample_cnt++;
    cnt  = (sc_reg == 0) ? 1 : (sc_reg > MAX_SAMPLES) ? MAX_SAMPLES : sc_reg;
    done = 1'b0;
    amps = '0;
    if (sample_cnt >= cnt) begin
      rs      = (rs_reg == 0) ? 1 : rs_reg;
      factor  = ct_reg / rs;
      mean    = acc / cnt;
      root    = int_sqrt(mean);
      product = factor * vpc_reg * root;
      cur     = longint'(product >> SCALE_SHIFT) - CUR_OFS_Q10;
      if (cur > OUT_MAX) begin
        cur = OUT_MAX;
      end
      amps       = cur[OUT_W-1:0];
      done       = 1'b1;
      sample_cnt = 0;
      offset_q8  = OFFSET_RESET_Q8;
      block_sum  = 0;
      block_cnt  = 0;
      acc        = 0;
    end
  endtask

  task automatic push_stim(input stim_op_e op, input logic [IN_W-1:0] word,
                           input int unsigned gap, input cfg_idx_e idx,
                           input logic [CFG_W-1:0] value);
    stim_t s;
    s.op    = op;
    s.word  = word;
    s.gap   = gap;
    s.idx   = idx;
    s.value = value;
    stim_q.push_back(s);
  endtask

  task automatic push_sample(input logic [IN_W-1:0] word, input int unsigned gap);
    push_stim(OP_SAMPLE, word, gap, CFG_SAMPLE_COUNT, '0);
  endtask

  task automatic push_cfg(input cfg_idx_e idx, input int unsigned value);
    int unsigned      w;
    logic [CFG_W-1:0] v;
    case (idx)
      CFG_SAMPLE_COUNT: w = SC_W;
      CFG_CT_RATIO:     w = CT_W;
      CFG_SENSE_RES:    w = RS_W;
      default:          w = VPC_W;
    endcase
    v = CFG_W'(value);
    if (w < CFG_W && $urandom_range(0, 3) == 0) begin
      v = v | (CFG_W'($urandom) << w);
    end
    push_stim(OP_CONFIG, '0, 0, idx, v);
  endtask

  // driver: hold the word until accepted, apply register writes only when idle
  always @(negedge clk_i) begin : driver
    logic             v_valid;
    logic [IN_W-1:0]  v_data;
    logic             v_we;
    cfg_idx_e         v_idx;
    logic [CFG_W-1:0] v_val;
    logic             v_hold;
    v_valid = s_axis_tvalid;
    v_data  = s_axis_tdata;
    v_we    = 1'b0;
    v_idx   = cfg_idx_i;
    v_val   = cfg_data_i;
    v_hold  = 1'b0;
    if (rst_ni && !(s_axis_tvalid && !in_fire)) begin
      v_valid = 1'b0;
      if (stim_q.size() != 0) begin
        case (stim_q[0].op)
          OP_SAMPLE: begin
            if (gap_seen < stim_q[0].gap) begin
              gap_seen++;
            end else begin
              v_valid  = 1'b1;
              v_data   = stim_q[0].word;
              gap_seen = 0;
              stim_q.delete(0);
            end
          end
          OP_CONFIG: begin
            if (rms_due.size() == 0 && quiet >= IDLE_WAIT) begin
              v_we  = 1'b1;
              v_idx = stim_q[0].idx;
              v_val = stim_q[0].value;
              stim_q.delete(0);
            end
          end
          OP_DRAIN: begin
            if (rms_due.size() == 0) begin
              stim_q.delete(0);
            end
          end
          default: begin
            v_hold = 1'b1;
            stim_q.delete(0);
          end
        endcase
      end
    end
    s_axis_tvalid <= v_valid;
    s_axis_tdata  <= v_data;
    cfg_we_i      <= v_we;
    cfg_idx_i     <= v_idx;
    cfg_data_i    <= v_val;
    hold_req      <= v_hold;
  end

  always @(posedge clk_i) begin : hold_off
    if (hold_req) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin : receiver
    logic v_ready;
    if (mode_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      mode_left = $urandom_range(200, 3000);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      v_ready = 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      v_ready = 1'b0;
    end else if (calm || $urandom_range(0, 2) != 0) begin
      v_ready = 1'b1;
    end else begin
      stall_left = pick_gap();
      v_ready    = 1'b0;
    end
    m_axis_tready <= v_ready;
  end

  always @(posedge clk_i) begin : monitor
    bit               done;
    logic [OUT_W-1:0] amps;
    logic [OUT_W-1:0] want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        cfg_shadow_write(cfg_idx_i, cfg_data_i);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rms_accumulate(s_axis_tdata, done, amps);
        if (done) begin
          rms_due.push_back(amps);
        end
        quiet <= 0;
      end else if (quiet < IDLE_WAIT) begin
        quiet <= quiet + 1;
      end
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (rms_due.size() == 0) begin
          $error("rms_current: expected none, actual %0d", $signed(m_axis_tdata));
          mismatches++;
        end else begin
          want = rms_due.pop_front();
          if (m_axis_tdata !== want) begin
            $error("rms_current: expected %0d, actual %0d", $signed(want),
                   $signed(m_axis_tdata));
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned sc;
    int unsigned n;
    int unsigned rand_items;
    int          center;
    int          spread;
    bit          calm_phase;

    push_cfg(CFG_SAMPLE_COUNT, 1);
    push_sample(IN_W'(0), 0);
    push_sample(IN_W'(ADC_MAX), 1);
    push_sample(IN_W'(510), 0);
    push_sample(IN_W'(511), 2);
    push_sample(IN_W'(509), 0);
    push_sample({IN_W{1'b1}}, 0);
    push_sample({{(IN_W - ADC_BITS){1'b1}}, {ADC_BITS{1'b0}}}, 3);
    push_cfg(CFG_SAMPLE_COUNT, 0);
    push_sample(IN_W'(100), 0);
    push_sample(IN_W'(900), 0);
    push_cfg(CFG_SENSE_RES, 0);
    push_cfg(CFG_CT_RATIO, (1 << CT_W) - 1);
    push_cfg(CFG_VOLTS_PER_COUNT, (1 << VPC_W) - 1);
    push_cfg(CFG_SAMPLE_COUNT, 1);
    push_sample(IN_W'(ADC_MAX), 0);
    push_sample(IN_W'(0), 0);
    push_cfg(CFG_CT_RATIO, 0);
    push_sample(IN_W'(700), 0);
    push_cfg(CFG_CT_RATIO, 50);
    push_cfg(CFG_SENSE_RES, 10000);
    push_sample(IN_W'(20), 0);
    push_cfg(CFG_CT_RATIO, 10000);
    push_cfg(CFG_SENSE_RES, 1);
    push_cfg(CFG_VOLTS_PER_COUNT, 1);
    push_sample(IN_W'(ADC_MAX), 0);
    // lower the count below the samples already taken
    push_cfg(CFG_SAMPLE_COUNT, 20);
    for (int i = 0; i < 8; i++) begin
      push_sample(make_word(512, 500), 0);
    end
    push_cfg(CFG_SAMPLE_COUNT, 5);
    push_sample(make_word(512, 500), 0);

    // stall the output long enough to back up the input
    push_cfg(CFG_VOLTS_PER_COUNT, VPC_RESET);
    push_cfg(CFG_SAMPLE_COUNT, 1);
    push_stim(OP_HOLD, '0, 0, CFG_SAMPLE_COUNT, '0);
    for (int i = 0; i < 24; i++) begin
      push_sample(make_word(512, 600), 0);
    end
    push_stim(OP_DRAIN, '0, 0, CFG_SAMPLE_COUNT, '0);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       sc = 0;
        1:       sc = $urandom_range(41, 300);
        default: sc = $urandom_range(1, 40);
      endcase
      push_cfg(CFG_SAMPLE_COUNT, sc);
      if ($urandom_range(0, 1) == 0) begin
        push_cfg(CFG_CT_RATIO, ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << CT_W) - 1)
                                                         : $urandom_range(1, 10000));
      end
      if ($urandom_range(0, 1) == 0) begin
        push_cfg(CFG_SENSE_RES, ($urandom_range(0, 9) == 0) ? $urandom_range(0, (1 << RS_W) - 1)
                                                          : $urandom_range(1, 100));
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0:       push_cfg(CFG_VOLTS_PER_COUNT, 1);
          1:       push_cfg(CFG_VOLTS_PER_COUNT, (1 << VPC_W) - 1);
          default: push_cfg(CFG_VOLTS_PER_COUNT, $urandom_range(1, (1 << VPC_W) - 1));
        endcase
      end
      n          = $urandom_range(1, 60);
      calm_phase = ($urandom_range(0, 3) == 0);
      center     = $urandom_range(0, ADC_MAX);
      spread     = $urandom_range(0, 600);
      for (int i = 0; i < n; i++) begin
        push_sample(make_word(center, spread), calm_phase ? 0 : pick_gap());
      end
      if ($urandom_range(0, 5) == 0) begin
        push_stim(OP_DRAIN, '0, 0, CFG_SAMPLE_COUNT, '0);
      end
      rand_items += n;
    end

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    while (stim_q.size() != 0 || s_axis_tvalid || rms_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (IDLE_WAIT) @(posedge clk_i);
    if (rms_due.size() != 0) begin
      $error("rms_current: %0d expected words never arrived", rms_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
